/* rtl/core/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, codes and the CRC-16/MODBUS byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    // Receive phase
    typedef enum logic [1:0] {
        PH_HUNT1  = 2'd0,
        PH_HUNT2  = 2'd1,
        PH_HEADER = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    // Result kinds
    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_GOOD    = 3'd1;
    localparam logic [2:0] K_BAD_CRC = 3'd2;
    localparam logic [2:0] K_ACK_DROP = 3'd3;
    localparam logic [2:0] K_TOO_LONG = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_ONE = 3'd0;
    localparam logic [2:0] CFG_START_TWO = 3'd1;
    localparam logic [2:0] CFG_MAX_LEN   = 3'd2;
    localparam logic [2:0] CFG_ACK_MASK  = 3'd3;
    localparam logic [2:0] CFG_NEED_MASK = 3'd4;

    // Frame layout and CRC constants
    localparam logic [16:0] HDR_SIZE = 17'd10;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration registers as seen by the parser
    typedef struct packed {
        logic [7:0]  start_one;
        logic [7:0]  start_two;
        logic [15:0] max_len;
        logic [7:0]  ack_mask;
        logic [7:0]  need_mask;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_cfg;
        logic [7:0]  frame_seq;
        logic [7:0]  frame_src;
        logic [7:0]  frame_dst;
        logic [7:0]  frame_func;
        logic [7:0]  frame_cmd;
        logic [15:0] payload_len;
        logic        wants_ack;
    } t_result;

    // Advance the reflected CRC by one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/crcfr_parser.sv */
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame state machine: start-byte hunt, header capture, payload streaming,
// running CRC and verdict. One byte is taken per accepted word.
// ----------------------------------------------------------------------------
module crcfr_parser
    import crcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_acc,
    input  logic [7:0] i_byte,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase      r_phase, n_phase;
    logic [16:0] r_byte_count, n_byte_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_trailer_low, n_trailer_low;
    logic [7:0]  r_hdr [8];
    logic [7:0]  n_hdr [8];

    logic [2:0]  hdr_idx;
    logic [15:0] hdr_len_next;
    logic [16:0] body_end;
    logic [15:0] crc_step;
    logic [15:0] recv_crc;
    logic        is_last_hdr;

    assign hdr_idx      = r_byte_count[2:0] - 3'd2;
    assign is_last_hdr  = (r_byte_count == (HDR_SIZE - 17'd1));
    assign hdr_len_next = {n_hdr[7], n_hdr[6]};
    assign body_end     = HDR_SIZE + {1'b0, r_hdr[7], r_hdr[6]};
    assign crc_step     = crc16_byte(r_crc, i_byte);
    assign recv_crc     = {i_byte, r_trailer_low};

    // Header store with the current byte written in
    always_comb begin
        n_hdr = r_hdr;
        if (r_phase == PH_HEADER) begin
            n_hdr[hdr_idx] = i_byte;
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == i_cfg.start_one) n_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                n_phase = (i_byte == i_cfg.start_two) ? PH_HEADER : PH_HUNT1;
            end
            PH_HEADER: begin
                if (is_last_hdr) begin
                    n_phase = (hdr_len_next > i_cfg.max_len) ? PH_HUNT1 : PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_byte_count > body_end) n_phase = PH_HUNT1;
            end
            default: n_phase = PH_HUNT1;
        endcase
    end

    // Counters, CRC, trailer and result
    always_comb begin
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_trailer_low = r_trailer_low;
        o_res_valid   = 1'b0;
        o_res.kind        = K_PAYLOAD;
        o_res.data_byte   = 8'd0;
        o_res.frame_cfg   = n_hdr[0];
        o_res.frame_seq   = n_hdr[1];
        o_res.frame_src   = n_hdr[2];
        o_res.frame_dst   = n_hdr[3];
        o_res.frame_func  = n_hdr[4];
        o_res.frame_cmd   = n_hdr[5];
        o_res.payload_len = hdr_len_next;
        o_res.wants_ack   = |(n_hdr[0] & i_cfg.need_mask);
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == i_cfg.start_one) begin
                    n_crc        = crc16_byte(CRC_INIT, i_byte);
                    n_byte_count = 17'd1;
                end
            end
            PH_HUNT2: begin
                if (i_byte == i_cfg.start_two) begin
                    n_crc        = crc_step;
                    n_byte_count = 17'd2;
                end else begin
                    n_crc         = CRC_INIT;
                    n_byte_count  = 17'd0;
                    n_trailer_low = 8'd0;
                end
            end
            PH_HEADER: begin
                n_crc        = crc_step;
                n_byte_count = r_byte_count + 17'd1;
                // drop an over-long frame and restart the hunt
                if (is_last_hdr && (hdr_len_next > i_cfg.max_len)) begin
                    o_res_valid   = 1'b1;
                    o_res.kind    = K_TOO_LONG;
                    n_crc         = CRC_INIT;
                    n_byte_count  = 17'd0;
                    n_trailer_low = 8'd0;
                end
            end
            PH_BODY: begin
                if (r_byte_count < body_end) begin
                    n_crc           = crc_step;
                    n_byte_count    = r_byte_count + 17'd1;
                    o_res_valid     = 1'b1;
                    o_res.kind      = K_PAYLOAD;
                    o_res.data_byte = i_byte;
                end else if (r_byte_count == body_end) begin
                    n_trailer_low = i_byte;
                    n_byte_count  = r_byte_count + 17'd1;
                end else begin
                    // verdict on the trailer high byte
                    o_res_valid = 1'b1;
                    if (|(r_hdr[0] & i_cfg.ack_mask)) begin
                        o_res.kind = K_ACK_DROP;
                    end else if (recv_crc == r_crc) begin
                        o_res.kind = K_GOOD;
                    end else begin
                        o_res.kind = K_BAD_CRC;
                    end
                    n_crc         = CRC_INIT;
                    n_byte_count  = 17'd0;
                    n_trailer_low = 8'd0;
                end
            end
            default: begin
                n_crc        = CRC_INIT;
                n_byte_count = 17'd0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT1;
            r_byte_count  <= 17'd0;
            r_crc         <= CRC_INIT;
            r_trailer_low <= 8'd0;
        end else if (i_acc) begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_trailer_low <= n_trailer_low;
        end
    end

    // Header bytes, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_hdr <= n_hdr;
        end
    end

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT1 |-> (r_byte_count == 17'd0 && r_crc == CRC_INIT))
        else $error("hunt phase with stale count or CRC");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> (r_byte_count >= 17'd2 && r_byte_count <= 17'd9))
        else $error("header byte count out of range");

    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == K_PAYLOAD) |-> r_phase == PH_BODY)
        else $error("payload word outside body phase");

endmodule

/* rtl/core/crcfr_out_reg.sv */
// ----------------------------------------------------------------------------
// crcfr_out_reg
// Result register between the parser and the output channel. Takes a new word
// in the cycle the previous one leaves.
// ----------------------------------------------------------------------------
module crcfr_out_reg
    import crcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_busy,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Full and stalled: hold the word and block the input side
    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !i_load)
        else $error("result overwritten while stalled");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_res == $past(i_res)))
        else $error("loaded word not presented");

endmodule

/* rtl/core/crc_checked_frame_receiver_core.sv */
// A result word is registered and valid in the cycle after its causing byte is accepted.
// Throughput: one byte per cycle unless stalled; parser and CRC update are combinational.
// The input stalls only while the result register is full and the output is stalled.
// Reset (i_rst_n low, synchronous) restores the configuration registers to their defaults,
// clears the output valid flag and returns the parser to the first start-byte hunt.
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_core
// Start-of-frame receiver with header capture, payload streaming and a
// CRC-16/MODBUS verdict per frame.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_core
    import crcfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_frame_cfg,
    output logic [7:0]  o_frame_seq,
    output logic [7:0]  o_frame_src,
    output logic [7:0]  o_frame_dst,
    output logic [7:0]  o_frame_func,
    output logic [7:0]  o_frame_cmd,
    output logic [15:0] o_payload_len,
    output logic        o_wants_ack,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_result res, out_res;
    logic    res_valid;
    logic    in_acc;
    logic    out_busy;

    assign o_in_stall = out_busy;
    assign in_acc     = i_in_valid && !out_busy;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_one <= 8'hA5;
            r_cfg.start_two <= 8'h5A;
            r_cfg.max_len   <= 16'd256;
            r_cfg.ack_mask  <= 8'h02;
            r_cfg.need_mask <= 8'h01;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_ONE: r_cfg.start_one <= i_cfg_wdata[7:0];
                CFG_START_TWO: r_cfg.start_two <= i_cfg_wdata[7:0];
                CFG_MAX_LEN:   r_cfg.max_len   <= i_cfg_wdata;
                CFG_ACK_MASK:  r_cfg.ack_mask  <= i_cfg_wdata[7:0];
                CFG_NEED_MASK: r_cfg.need_mask <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    crcfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_byte      (i_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crcfr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc && res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_busy  (out_busy),
        .o_res   (out_res)
    );

    // Drive the result fields
    assign o_kind        = out_res.kind;
    assign o_data_byte   = out_res.data_byte;
    assign o_frame_cfg   = out_res.frame_cfg;
    assign o_frame_seq   = out_res.frame_seq;
    assign o_frame_src   = out_res.frame_src;
    assign o_frame_dst   = out_res.frame_dst;
    assign o_frame_func  = out_res.frame_func;
    assign o_frame_cmd   = out_res.frame_cmd;
    assign o_payload_len = out_res.payload_len;
    assign o_wants_ack   = out_res.wants_ack;

endmodule
